### design/lsps_pkg.sv
package lsps_pkg;

  localparam int MAX_LEDS_DEF = 256;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int BITS_PER_LED = 24;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_STRIP_LENGTH    = 3'd0,
    REG_ONE_HIGH_TICKS  = 3'd1,
    REG_ONE_LOW_TICKS   = 3'd2,
    REG_ZERO_HIGH_TICKS = 3'd3,
    REG_ZERO_LOW_TICKS  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] led_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } item_t;

  typedef struct packed {
    logic       line_level;
    logic       busy_res;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    status_t    status;
    logic       frame_done;
  } result_t;

  typedef struct packed {
    logic [8:0] strip_length;
    logic [7:0] one_high_ticks;
    logic [7:0] one_low_ticks;
    logic [7:0] zero_high_ticks;
    logic [7:0] zero_low_ticks;
  } cfg_t;

  // a programmed phase length of zero behaves as one tick
  function automatic logic [7:0] phase_ticks(input logic [7:0] t);
    phase_ticks = (t == 8'd0) ? 8'd1 : t;
  endfunction

endpackage

### design/lsps_cfg.sv
module lsps_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lsps_pkg::ADDR_W-1:0] paddr,
  input  logic [lsps_pkg::DATA_W-1:0] pwdata,
  output logic [lsps_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output lsps_pkg::cfg_t            cfg
);
  import lsps_pkg::*;

  logic     wr_en;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strip_length    <= 9'd256;
      cfg.one_high_ticks  <= 8'd40;
      cfg.one_low_ticks   <= 8'd23;
      cfg.zero_high_ticks <= 8'd20;
      cfg.zero_low_ticks  <= 8'd43;
    end else if (wr_en) begin
      case (reg_sel)
        REG_STRIP_LENGTH:    cfg.strip_length    <= pwdata[8:0];
        REG_ONE_HIGH_TICKS:  cfg.one_high_ticks  <= pwdata[7:0];
        REG_ONE_LOW_TICKS:   cfg.one_low_ticks   <= pwdata[7:0];
        REG_ZERO_HIGH_TICKS: cfg.zero_high_ticks <= pwdata[7:0];
        REG_ZERO_LOW_TICKS:  cfg.zero_low_ticks  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_STRIP_LENGTH:    prdata = DATA_W'(cfg.strip_length);
      REG_ONE_HIGH_TICKS:  prdata = DATA_W'(cfg.one_high_ticks);
      REG_ONE_LOW_TICKS:   prdata = DATA_W'(cfg.one_low_ticks);
      REG_ZERO_HIGH_TICKS: prdata = DATA_W'(cfg.zero_high_ticks);
      REG_ZERO_LOW_TICKS:  prdata = DATA_W'(cfg.zero_low_ticks);
      default:             prdata = '0;
    endcase
  end

endmodule

### design/led_strip_pixel_serializer_top.sv
// each item passes through the input stage and then the result register before its result is ready
// throughput: one item per cycle while result_ready is held high, both for pixel commands and for ticks
// pixel store reads go through registered memory ports: the input stage holds the fetched
// pixel, a second port prefetches the next pixel of a frame while the current one shifts out
// reset (rst, synchronous): pipeline empty, line idle, registers at their defaults;
// pixel store contents are not cleared and must be written before they are read
module led_strip_pixel_serializer_top #(
  parameter int MAX_LEDS = lsps_pkg::MAX_LEDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  lsps_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output lsps_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsps_pkg::ADDR_W-1:0] paddr,
  input  logic [lsps_pkg::DATA_W-1:0] pwdata,
  output logic [lsps_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import lsps_pkg::*;

  localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int USE_W = ($clog2(MAX_LEDS + 1) > 9) ? $clog2(MAX_LEDS + 1) : 9;

  cfg_t cfg;

  lsps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pipeline control
  logic  s1_valid;
  item_t s1;
  logic  advance;
  logic  accept;

  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;
  assign accept     = item_valid && item_ready;

  // pixel store, kept in wire order {green, red, blue}
  logic [23:0]      mem [MAX_LEDS];
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] pf_addr;
  logic [23:0]      rd_data;
  logic [23:0]      pf_data;
  logic             fwd_hit;
  logic [23:0]      fwd_data;
  logic [23:0]      s1_pixel;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [23:0]      wr_data;

  // frame state
  logic             sending;
  logic [IDX_W-1:0] led_pos;
  logic [4:0]       bit_pos;
  logic [23:0]      shift_word;
  logic             in_high;
  logic [7:0]       tick_cnt;

  logic             sending_next;
  logic [IDX_W-1:0] led_pos_next;
  logic [4:0]       bit_pos_next;
  logic [23:0]      shift_word_next;
  logic             in_high_next;
  logic [7:0]       tick_cnt_next;
  result_t          res_next;

  assign rd_addr = (item.command == CMD_START) ? '0 : IDX_W'(item.led_index);
  assign pf_addr = led_pos + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data  <= mem[rd_addr];
      // a write leaving the input stage in the same cycle is not yet in rd_data
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
    pf_data <= mem[pf_addr];
  end

  assign s1_pixel = fwd_hit ? fwd_data : rd_data;

  // item processing
  logic [USE_W-1:0] in_use;
  logic [USE_W-1:0] pos_inc;
  logic [7:0]       tick_inc;
  logic [7:0]       phase_len;
  logic             bit_one;

  always_comb begin
    in_use = (USE_W'(cfg.strip_length) > USE_W'(MAX_LEDS)) ? USE_W'(MAX_LEDS)
                                                          : USE_W'(cfg.strip_length);
    bit_one  = shift_word[23];
    tick_inc = tick_cnt + 8'd1;
    pos_inc  = USE_W'(led_pos) + USE_W'(1);
    if (bit_one) begin
      phase_len = in_high ? phase_ticks(cfg.one_high_ticks) : phase_ticks(cfg.one_low_ticks);
    end else begin
      phase_len = in_high ? phase_ticks(cfg.zero_high_ticks) : phase_ticks(cfg.zero_low_ticks);
    end

    sending_next    = sending;
    led_pos_next    = led_pos;
    bit_pos_next    = bit_pos;
    shift_word_next = shift_word;
    in_high_next    = in_high;
    tick_cnt_next   = tick_cnt;
    wr_en           = 1'b0;
    wr_addr         = IDX_W'(s1.led_index);
    wr_data         = {s1.green_in, s1.red_in, s1.blue_in};
    res_next        = '0;
    res_next.status = ST_OK;

    if (s1.command == CMD_TICK) begin
      if (sending) begin
        res_next.line_level = in_high;
        tick_cnt_next       = tick_inc;
        if (tick_inc >= phase_len) begin
          tick_cnt_next = '0;
          if (in_high) begin
            in_high_next = 1'b0;
          end else begin
            in_high_next    = 1'b1;
            shift_word_next = {shift_word[22:0], 1'b0};
            bit_pos_next    = bit_pos + 5'd1;
            if (bit_pos == 5'(BITS_PER_LED - 1)) begin
              bit_pos_next = '0;
              if (pos_inc >= in_use) begin
                sending_next        = 1'b0;
                in_high_next        = 1'b0;
                led_pos_next        = '0;
                shift_word_next     = '0;
                res_next.frame_done = 1'b1;
              end else begin
                led_pos_next    = IDX_W'(pos_inc);
                shift_word_next = pf_data;
              end
            end
          end
        end
      end
    end else if (sending) begin
      res_next.status = ST_BUSY;
    end else if (s1.command == CMD_START) begin
      if (in_use != '0) begin
        sending_next    = 1'b1;
        led_pos_next    = '0;
        bit_pos_next    = '0;
        tick_cnt_next   = '0;
        in_high_next    = 1'b1;
        shift_word_next = s1_pixel;
      end
    end else if (USE_W'(s1.led_index) >= in_use) begin
      res_next.status = ST_RANGE;
    end else if (s1.command == CMD_WRITE) begin
      wr_en = advance;
    end else begin
      res_next.green_out = s1_pixel[23:16];
      res_next.red_out   = s1_pixel[15:8];
      res_next.blue_out  = s1_pixel[7:0];
    end

    res_next.busy_res = sending || sending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      sending      <= 1'b0;
      led_pos      <= '0;
      bit_pos      <= '0;
      shift_word   <= '0;
      in_high      <= 1'b0;
      tick_cnt     <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        sending      <= sending_next;
        led_pos      <= led_pos_next;
        bit_pos      <= bit_pos_next;
        shift_word   <= shift_word_next;
        in_high      <= in_high_next;
        tick_cnt     <= tick_cnt_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= item;
    end
    if (advance) begin
      result <= res_next;
    end
  end

endmodule

### design/lsps_checker.sv
module lsps_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input lsps_pkg::result_t result
);
  import lsps_pkg::*;

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // stalled result transfer keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // end of frame is flagged only on a busy, clean tick
  a_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_done |-> result.busy_res && result.status == ST_OK
      && !result.line_level)
    else $error("frame done without a frame in progress");

  // a high line only comes from a frame tick, never with pixel data or an error
  a_level: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.line_level |-> result.busy_res && result.status == ST_OK
      && result.red_out == 8'd0 && result.green_out == 8'd0 && result.blue_out == 8'd0)
    else $error("line high outside a frame tick");

endmodule

bind led_strip_pixel_serializer_top lsps_checker u_lsps_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
